@@ sv/pee_pkg.sv @@
// ----------------------------------------------------------------------------
// pee_pkg: shared definitions for the postfix expression evaluator
// Character codes, status codes, operator codes and sequencer states.
// ----------------------------------------------------------------------------
package pee_pkg;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_NL    = 8'h0a;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_STAR  = 8'h2a;
	localparam logic [7:0] CH_SLASH = 8'h2f;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_UNDERFLOW  = 3'd1;
	localparam logic [2:0] ST_DIVZERO    = 3'd2;
	localparam logic [2:0] ST_NOT_SINGLE = 3'd3;
	localparam logic [2:0] ST_OVERFLOW   = 3'd4;

	localparam int         WORD_W   = 32;
	localparam logic [4:0] DIV_LAST = 5'd31;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_LIT   = 9'b000000010,
		S_DISP  = 9'b000000100,
		S_OPCHK = 9'b000001000,
		S_RDB   = 9'b000010000,
		S_EXEC  = 9'b000100000,
		S_DIV   = 9'b001000000,
		S_WB    = 9'b010000000,
		S_NL    = 9'b100000000
	} state_t;

endpackage

@@ sv/postfix_expression_evaluator.sv @@
// ----------------------------------------------------------------------------
// postfix_expression_evaluator: reverse polish integer evaluator
// A digit word is taken without a stall. Any other word then stalls the input
// for dispatch, plus a literal push, a pending subtract, an operator, or a
// divide (one quotient bit per cycle in the restoring divider).
// The newline result waits in the output register while input continues; the
// next newline stalls until that register has been taken.
// arst_n clears stack count, literal state and error; stack RAM is not reset.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator import pee_pkg::*; #(
	parameter int STACK_DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               ch_valid,
	output logic               ch_stall,
	input  logic [7:0]         ch,
	output logic               res_valid,
	input  logic               res_stall,
	output logic signed [31:0] value,
	output logic [2:0]         status
);

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);

	state_t              state_q;
	logic [CW-1:0]       cnt_q;
	logic [WORD_W-1:0]   acc_q;
	logic                innum_q;
	logic                neg_q;
	logic                pminus_q;
	logic [2:0]          err_q;
	logic                mpass_q;
	logic [4:0]          dcnt_q;
	logic                out_valid_q;

	logic [7:0]          ch_q;
	op_t                 op_q;
	logic [WORD_W-1:0]   rhs_q;
	logic [WORD_W-1:0]   res_q;
	logic [WORD_W-1:0]   rem_q;
	logic [WORD_W-1:0]   quo_q;
	logic [WORD_W-1:0]   dvs_q;
	logic                qneg_q;
	logic [WORD_W-1:0]   value_q;
	logic [2:0]          status_q;

	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [WORD_W-1:0]   ram_wdata;
	logic [AW-1:0]       ram_raddr;
	logic [WORD_W-1:0]   ram_rdata;

	logic                is_digit;
	logic [WORD_W-1:0]   digit;
	logic [WORD_W-1:0]   acc_next;
	logic [WORD_W-1:0]   lit_val;
	logic                lit_ok;
	logic [CW-1:0]       cm1;
	logic [CW-1:0]       cm2;
	logic [WORD_W:0]     trial;
	logic [WORD_W:0]     diff;
	logic [WORD_W-1:0]   lhs_mag;
	logic [WORD_W-1:0]   rhs_mag;
	logic [WORD_W-1:0]   quo_fin;
	logic                out_load;
	logic                nl_single;
	state_t              op_done;

	assign is_digit = (ch inside {[CH_ZERO:CH_NINE]});
	assign digit    = {{(WORD_W-8){1'b0}}, ch - CH_ZERO};
	assign acc_next = (acc_q << 3) + (acc_q << 1) + digit;
	assign lit_val  = neg_q ? (32'd0 - acc_q) : acc_q;
	assign lit_ok   = (err_q == ST_OK) && (cnt_q != CW'(STACK_DEPTH));
	assign cm1      = cnt_q - CW'(1);
	assign cm2      = cnt_q - CW'(2);

	// one restoring divide step per cycle
	assign trial = {rem_q, quo_q[WORD_W-1]};
	assign diff  = trial - {1'b0, dvs_q};

	assign lhs_mag = ram_rdata[WORD_W-1] ? (32'd0 - ram_rdata) : ram_rdata;
	assign rhs_mag = rhs_q[WORD_W-1] ? (32'd0 - rhs_q) : rhs_q;
	assign quo_fin = qneg_q ? (32'd0 - quo_q) : quo_q;

	assign out_load  = !out_valid_q || !res_stall;
	assign nl_single = (err_q == ST_OK) && (cnt_q == CW'(1));
	assign op_done   = mpass_q ? S_DISP : S_IDLE;

	assign ram_we    = ((state_q == S_LIT) && lit_ok) || (state_q == S_WB);
	assign ram_waddr = (state_q == S_WB) ? cm2[AW-1:0] : cnt_q[AW-1:0];
	assign ram_wdata = (state_q == S_WB) ? ((op_q == OP_DIV) ? quo_fin : res_q) : lit_val;

	always_comb begin
		case (state_q)
			S_OPCHK: ram_raddr = cm1[AW-1:0];
			S_RDB:   ram_raddr = cm2[AW-1:0];
			default: ram_raddr = '0;
		endcase
	end

	pee_ram #(
		.WIDTH (WORD_W),
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign ch_stall  = (state_q != S_IDLE);
	assign res_valid = out_valid_q;
	assign value     = value_q;
	assign status    = status_q;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			acc_q       <= '0;
			innum_q     <= 1'b0;
			neg_q       <= 1'b0;
			pminus_q    <= 1'b0;
			err_q       <= ST_OK;
			mpass_q     <= 1'b0;
			dcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_NL && out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !res_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (ch_valid) begin
						if (is_digit) begin
							if (innum_q) begin
								acc_q <= acc_next;
							end else begin
								innum_q  <= 1'b1;
								neg_q    <= pminus_q;
								pminus_q <= 1'b0;
								acc_q    <= digit;
							end
						end else if (innum_q) begin
							state_q <= S_LIT;
						end else if (pminus_q) begin
							pminus_q <= 1'b0;
							mpass_q  <= 1'b1;
							state_q  <= S_OPCHK;
						end else begin
							state_q <= S_DISP;
						end
					end
				end
				S_LIT: begin
					if (lit_ok) begin
						cnt_q <= cnt_q + CW'(1);
					end else if (err_q == ST_OK) begin
						err_q <= ST_OVERFLOW;
					end
					innum_q <= 1'b0;
					neg_q   <= 1'b0;
					acc_q   <= '0;
					if (pminus_q) begin
						pminus_q <= 1'b0;
						mpass_q  <= 1'b1;
						state_q  <= S_OPCHK;
					end else begin
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					case (ch_q)
						CH_PLUS, CH_STAR, CH_SLASH: begin
							mpass_q <= 1'b0;
							state_q <= S_OPCHK;
						end
						CH_MINUS: begin
							pminus_q <= 1'b1;
							state_q  <= S_IDLE;
						end
						CH_NL: begin
							state_q <= S_NL;
						end
						default: begin
							state_q <= S_IDLE;
						end
					endcase
				end
				S_OPCHK: begin
					if (err_q != ST_OK) begin
						state_q <= op_done;
					end else if (cnt_q < CW'(2)) begin
						err_q   <= ST_UNDERFLOW;
						state_q <= op_done;
					end else begin
						state_q <= S_RDB;
					end
				end
				S_RDB: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (op_q == OP_DIV) begin
						if (rhs_q == '0) begin
							err_q   <= ST_DIVZERO;
							state_q <= op_done;
						end else begin
							dcnt_q  <= '0;
							state_q <= S_DIV;
						end
					end else begin
						state_q <= S_WB;
					end
				end
				S_DIV: begin
					dcnt_q <= dcnt_q + 5'd1;
					if (dcnt_q == DIV_LAST) begin
						state_q <= S_WB;
					end
				end
				S_WB: begin
					cnt_q   <= cm1;
					state_q <= op_done;
				end
				S_NL: begin
					if (out_load) begin
						cnt_q       <= '0;
						err_q       <= ST_OK;
						acc_q       <= '0;
						innum_q     <= 1'b0;
						neg_q       <= 1'b0;
						pminus_q    <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// operands, divider and result word
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (ch_valid) begin
					ch_q <= ch;
					op_q <= OP_SUB;
				end
			end
			S_LIT: begin
				op_q <= OP_SUB;
			end
			S_DISP: begin
				case (ch_q)
					CH_PLUS:  op_q <= OP_ADD;
					CH_STAR:  op_q <= OP_MUL;
					CH_SLASH: op_q <= OP_DIV;
					default:  op_q <= op_q;
				endcase
			end
			S_RDB: begin
				rhs_q <= ram_rdata;
			end
			S_EXEC: begin
				case (op_q)
					OP_ADD:  res_q <= ram_rdata + rhs_q;
					OP_SUB:  res_q <= ram_rdata - rhs_q;
					OP_MUL:  res_q <= ram_rdata * rhs_q;
					default: res_q <= res_q;
				endcase
				rem_q  <= '0;
				quo_q  <= lhs_mag;
				dvs_q  <= rhs_mag;
				qneg_q <= ram_rdata[WORD_W-1] ^ rhs_q[WORD_W-1];
			end
			S_DIV: begin
				rem_q <= diff[WORD_W] ? trial[WORD_W-1:0] : diff[WORD_W-1:0];
				quo_q <= {quo_q[WORD_W-2:0], !diff[WORD_W]};
			end
			S_NL: begin
				if (out_load) begin
					value_q  <= nl_single ? ram_rdata : '0;
					status_q <= (err_q != ST_OK) ? err_q :
						(nl_single ? ST_OK : ST_NOT_SINGLE);
				end
			end
			default: begin
			end
		endcase
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(STACK_DEPTH))
		else $error("stack count beyond depth");

	a_err_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && status != ST_OK) |-> (value == 32'sd0))
		else $error("error word carries a nonzero value");

	a_nl_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_NL && out_load) |=> (cnt_q == '0 && err_q == ST_OK && res_valid))
		else $error("newline did not clear expression state");

	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (ch_stall && op_q == OP_DIV && dvs_q != '0))
		else $error("divider running without a valid divide");

endmodule

@@ sv/pee_ram.sv @@
// ----------------------------------------------------------------------------
// pee_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module pee_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: postfix expression evaluator
// Feeds character words from directed lines, random well-formed expressions,
// deep stacks, token soup and byte noise. A scoreboard predicts each newline
// result and compares it, in order, with the value and status that come out.
// ----------------------------------------------------------------------------
module testbench import pee_pkg::*; ();

	localparam int STACK_DEPTH = 64;
	localparam int RANDOM_CHARS = 1600;

	typedef struct {
		logic [31:0] value;
		logic [2:0]  status;
	} expr_result_t;

	class expr_scoreboard;
		logic [31:0]  operands [STACK_DEPTH];
		int unsigned  depth;
		logic [31:0]  accum;
		bit           in_literal;
		bit           literal_neg;
		bit           minus_held;
		logic [2:0]   err;
		expr_result_t expected_results [$];
		int           fails;

		function void clear();
			depth       = 0;
			accum       = '0;
			in_literal  = 1'b0;
			literal_neg = 1'b0;
			minus_held  = 1'b0;
			err         = ST_OK;
		endfunction

		function void push(logic [31:0] v);
			if (err != ST_OK)
				return;
			if (depth >= STACK_DEPTH) begin
				err = ST_OVERFLOW;
				return;
			end
			operands[depth] = v;
			depth++;
		endfunction

		function logic [31:0] quotient(logic [31:0] a, logic [31:0] b);
			logic [31:0] ma;
			logic [31:0] mb;
			logic [31:0] q;
			ma = a[31] ? -a : a;
			mb = b[31] ? -b : b;
			q  = ma / mb;
			return (a[31] != b[31]) ? -q : q;
		endfunction

		function void apply(op_t op);
			logic [31:0] lhs;
			logic [31:0] rhs;
			logic [31:0] r;
			if (err != ST_OK)
				return;
			if (depth < 2) begin
				err = ST_UNDERFLOW;
				return;
			end
			rhs = operands[depth - 1];
			lhs = operands[depth - 2];
			if (op == OP_DIV && rhs == 0) begin
				err = ST_DIVZERO;
				return;
			end
			depth -= 2;
			case (op)
				OP_ADD: r = lhs + rhs;
				OP_SUB: r = lhs - rhs;
				OP_MUL: r = lhs * rhs;
				default: r = quotient(lhs, rhs);
			endcase
			push(r);
		endfunction

		function void note_char(logic [7:0] c);
			expr_result_t res;
			if (c >= CH_ZERO && c <= CH_NINE) begin
				if (in_literal) begin
					accum = accum * 10 + 32'(c - CH_ZERO);
				end else begin
					in_literal  = 1'b1;
					literal_neg = minus_held;
					minus_held  = 1'b0;
					accum       = 32'(c - CH_ZERO);
				end
				return;
			end
			// whatever ends a literal is still handled as its own token
			if (in_literal) begin
				push(literal_neg ? -accum : accum);
				in_literal  = 1'b0;
				literal_neg = 1'b0;
				accum       = '0;
			end
			if (minus_held) begin
				minus_held = 1'b0;
				apply(OP_SUB);
			end
			case (c)
				CH_PLUS:  apply(OP_ADD);
				CH_STAR:  apply(OP_MUL);
				CH_SLASH: apply(OP_DIV);
				CH_MINUS: minus_held = 1'b1;
				CH_NL: begin
					res.status = err;
					res.value  = '0;
					if (err == ST_OK) begin
						if (depth == 1)
							res.value = operands[0];
						else
							res.status = ST_NOT_SINGLE;
					end
					expected_results.push_back(res);
					clear();
				end
				default: ;
			endcase
		endfunction

		function void check_result(logic [31:0] v, logic [2:0] s);
			expr_result_t exp_res;
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result value %0d status %0d", $time,
					$signed(v), s);
				fails++;
				return;
			end
			exp_res = expected_results.pop_front();
			if (v !== exp_res.value) begin
				$display("%0t: value mismatch, expected %0d, actual %0d", $time,
					$signed(exp_res.value), $signed(v));
				fails++;
			end
			if (s !== exp_res.status) begin
				$display("%0t: status mismatch, expected %0d, actual %0d", $time,
					exp_res.status, s);
				fails++;
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               ch_valid;
	logic               ch_stall;
	logic [7:0]         ch;
	logic               res_valid;
	logic               res_stall;
	logic signed [31:0] value;
	logic [2:0]         status;

	expr_scoreboard expr_board = new;
	int sender_idle_pct;
	int receiver_idle_pct;
	int chars_sent;
	logic hold_req;
	bit hold_done;
	int hold_left;

	postfix_expression_evaluator #(.STACK_DEPTH(STACK_DEPTH)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.ch_valid  (ch_valid),
		.ch_stall  (ch_stall),
		.ch        (ch),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.value     (value),
		.status    (status)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	initial begin
		#4_000_000;
		$display("testbench: FAIL");
		$finish;
	end

	// result side: check each accepted word, then pick the next stall
	always @(posedge clk) begin
		if (res_valid === 1'b1 && res_stall === 1'b0)
			expr_board.check_result(value, status);
		if (hold_req && !hold_done) begin
			hold_left = 400;
			hold_done = 1'b1;
		end
		if (hold_left > 0)
			hold_left--;
		res_stall <= (hold_left > 0) || ($urandom_range(99) < receiver_idle_pct);
	end

	task automatic send_char(input logic [7:0] c);
		while ($urandom_range(99) < sender_idle_pct) begin
			ch_valid <= 1'b0;
			@(posedge clk);
		end
		ch       <= c;
		ch_valid <= 1'b1;
		@(posedge clk);
		while (ch_stall) @(posedge clk);
		expr_board.note_char(c);
		chars_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i]);
	endtask

	task automatic wait_drained();
		ch_valid <= 1'b0;
		while (expr_board.expected_results.size() != 0) @(posedge clk);
	endtask

	function automatic logic [7:0] op_char(op_t op);
		case (op)
			OP_ADD: return CH_PLUS;
			OP_SUB: return CH_MINUS;
			OP_MUL: return CH_STAR;
			default: return CH_SLASH;
		endcase
	endfunction

	// mostly spaces, sometimes any byte that is not a token or a newline
	task automatic send_sep();
		logic [7:0] c;
		if ($urandom_range(3) != 0) begin
			send_char(" ");
			return;
		end
		do
			c = 8'($urandom_range(255));
		while ((c >= CH_ZERO && c <= CH_NINE) || c == CH_PLUS || c == CH_MINUS ||
			c == CH_STAR || c == CH_SLASH || c == CH_NL);
		send_char(c);
	endtask

	task automatic send_literal();
		logic [31:0] mag;
		string digits;
		int n;
		if ($urandom_range(3) == 0)
			send_char(CH_MINUS);
		case ($urandom_range(4))
			0, 1: begin
				mag = $urandom_range(9);
				digits = $sformatf("%0d", mag);
			end
			2: begin
				mag = $urandom_range(999);
				digits = $sformatf("%0d", mag);
			end
			3: begin
				mag = $urandom;
				digits = $sformatf("%0d", mag);
			end
			default: begin
				// long runs wrap the accumulator
				digits = "";
				n = $urandom_range(11, 13);
				repeat (n) digits = $sformatf("%s%0d", digits, $urandom_range(9));
			end
		endcase
		send_text(digits);
	endtask

	task automatic send_expr();
		int depth;
		int pushed;
		int n_lit;
		bit need_sep;
		op_t op;
		depth = 0;
		pushed = 0;
		need_sep = 1'b0;
		n_lit = $urandom_range(1, 8);
		while (pushed < n_lit || depth > 1) begin
			if (pushed < n_lit && (depth < 2 || $urandom_range(1) == 0)) begin
				if (need_sep || $urandom_range(2) == 0)
					send_sep();
				send_literal();
				pushed++;
				depth++;
				need_sep = 1'b1;
			end else begin
				if ($urandom_range(1) == 0)
					send_sep();
				op = op_t'($urandom_range(3));
				send_char(op_char(op));
				depth--;
				// a digit right after a minus would turn it into a sign
				need_sep = (op == OP_SUB);
			end
		end
		if ($urandom_range(2) == 0)
			send_sep();
		send_char(CH_NL);
	endtask

	// many pushes, which may reach or pass the top of the stack
	task automatic send_deep();
		int k;
		k = $urandom_range(40, 72);
		repeat (k) begin
			send_char(8'(CH_ZERO + $urandom_range(9)));
			send_char(" ");
		end
		repeat (k - 1) send_char(op_char(op_t'($urandom_range(2))));
		send_char(CH_NL);
	endtask

	task automatic send_soup();
		string alphabet;
		int n;
		alphabet = "0123456789+-*/  -";
		n = $urandom_range(1, 12);
		repeat (n) send_char(alphabet[$urandom_range(alphabet.len() - 1)]);
		send_char(CH_NL);
	endtask

	task automatic send_noise();
		int n;
		n = $urandom_range(1, 16);
		repeat (n) send_char(8'($urandom_range(255)));
		send_char(CH_NL);
	endtask

	task automatic send_line();
		int pick;
		pick = $urandom_range(99);
		if (pick < 72)
			send_expr();
		else if (pick < 76)
			send_deep();
		else if (pick < 79)
			send_text("-2147483648 -1/\n");
		else if (pick < 91)
			send_soup();
		else
			send_noise();
	endtask

	initial begin
		int goal;
		arst_n = 1'b0;
		ch_valid = 1'b0;
		ch = '0;
		res_stall = 1'b0;
		hold_req = 1'b0;
		sender_idle_pct = 0;
		receiver_idle_pct = 0;
		chars_sent = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: held minus before newline, signed literal, empty line,
		// underflow, zero divisor, odd separators and extreme bytes
		send_text("7 3-\n");
		send_text("-6 2/\n");
		send_text("\n");
		send_text("+\n");
		send_text("1 0/\n");
		send_text("2");
		send_char(8'h00);
		send_text("3");
		send_char(8'hff);
		send_text("*\n");

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					sender_idle_pct = 20;
					receiver_idle_pct = 57;
				end
				1: begin
					sender_idle_pct = 57;
					receiver_idle_pct = 20;
				end
				default: begin
					sender_idle_pct = 0;
					receiver_idle_pct = 0;
					hold_req <= 1'b1;
				end
			endcase
			goal = chars_sent + RANDOM_CHARS / 3;
			while (chars_sent < goal)
				send_line();
			if (phase == 0)
				wait_drained();
		end
		ch_valid <= 1'b0;

		while (expr_board.expected_results.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (expr_board.fails == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
